// ----- rtl/pidpd_pkg.sv -----
// Package for the gated PID core: widths, register indexes and shared types.
package pidpd_pkg;

  // Fixed point and sample sizes
  localparam int FRAC_BITS    = 8;
  localparam int SAMPLE_WIDTH = 16;

  // Field widths fixed by the register map and the result
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int GATE_W  = 16;
  localparam int CFG_W   = 16;
  localparam int DRIVE_W = 16;

  // Derived internal widths
  localparam int ERR_W  = SAMPLE_WIDTH + 1;              // target - measured
  localparam int ACC_W  = LIMIT_W + FRAC_BITS + 1;       // clamped Q values
  localparam int CMP_W  = (ERR_W > GATE_W) ? ERR_W : GATE_W;
  localparam int PROD_W = GAIN_W + ERR_W + 2;            // gain times second difference
  localparam int SUM_A  = PROD_W + 3;
  localparam int SUM_W  = (SUM_A > ACC_W + 3) ? SUM_A : ACC_W + 3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEG    = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_OUTPUT_LIMIT  = 3'd3,
    REG_INTEG_LIMIT   = 3'd4,
    REG_ERROR_CEILING = 3'd5,
    REG_DEAD_ZONE     = 3'd6,
    REG_LOOP_FORM     = 3'd7
  } cfg_reg_e;

  // Loop form select
  typedef enum logic {
    FORM_POSITION    = 1'b0,
    FORM_INCREMENTAL = 1'b1
  } loop_form_e;

endpackage

// ----- rtl/pid_position_delta_gated_core.sv -----
// Gated PID core, position or incremental, one request per cycle unless stalled.
//
// Usage: a request carries measured_i and target_i and is taken at a clock edge
// with in_valid_i high and in_stall_o low. Each request yields exactly one
// result (drive_o, gated_o), offered with out_valid_o and taken at an edge
// where out_stall_i is low. Results leave in request order.
// The request is captured in an input register, and the error, three gain
// multiplies, the integral clamp and the output clamp run in one combinational
// pass into the result register and the loop state.
// Throughput is one request per cycle unless stalled; the figure is set by the
// integral and previous-output feedback, which closes in that single pass.
// When the receiver stalls, the result register holds its value; the input
// register still takes one more request if empty, then in_stall_o rises until
// the result is taken.
// Reset (rst_ni low, asynchronous) empties both registers, clears the integral,
// error history and previous output, and loads the register reset values.
// Configuration writes (cfg_we_i) act at once; the user must make them when idle.
module pid_position_delta_gated_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [2:0]                             cfg_index_i,
  input  logic [pidpd_pkg::CFG_W-1:0]            cfg_wdata_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pidpd_pkg::SAMPLE_WIDTH-1:0] measured_i,
  input  logic signed [pidpd_pkg::SAMPLE_WIDTH-1:0] target_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pidpd_pkg::DRIVE_W-1:0]   drive_o,
  output logic                                   gated_o
);
  import pidpd_pkg::*;

  // Symmetric clamp
  function automatic logic signed [SUM_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] v,
                                                        input logic signed [SUM_W-1:0] lim);
    logic signed [SUM_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Configuration registers
  logic signed [GAIN_W-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
  logic        [LIMIT_W-1:0] output_limit_q, integ_limit_q;
  logic        [GATE_W-1:0]  error_ceiling_q, dead_zone_q;
  loop_form_e                loop_form_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q     <= '0;
      gain_integ_q    <= '0;
      gain_deriv_q    <= '0;
      output_limit_q  <= '1;
      integ_limit_q   <= '1;
      error_ceiling_q <= '0;
      dead_zone_q     <= '0;
      loop_form_q     <= FORM_POSITION;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GAIN_PROP:     gain_prop_q     <= GAIN_W'(cfg_wdata_i);
        REG_GAIN_INTEG:    gain_integ_q    <= GAIN_W'(cfg_wdata_i);
        REG_GAIN_DERIV:    gain_deriv_q    <= GAIN_W'(cfg_wdata_i);
        REG_OUTPUT_LIMIT:  output_limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_INTEG_LIMIT:   integ_limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
        REG_ERROR_CEILING: error_ceiling_q <= GATE_W'(cfg_wdata_i);
        REG_DEAD_ZONE:     dead_zone_q     <= GATE_W'(cfg_wdata_i);
        REG_LOOP_FORM:     loop_form_q     <= loop_form_e'(cfg_wdata_i[0]);
        default: ;
      endcase
    end
  end

  // Handshake: result register frees up when empty or being taken
  logic s1_valid_q, out_valid_q;
  logic out_ready, s1_ready, in_take, s1_fire;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_take    = in_valid_i && s1_ready;
  assign s1_fire    = s1_valid_q && out_ready;

  // Input register
  logic signed [SAMPLE_WIDTH-1:0] meas_q, tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      meas_q <= measured_i;
      tgt_q  <= target_i;
    end
  end

  // Loop state
  logic signed [ACC_W-1:0] integ_acc_q, out_prev_q;
  logic signed [ERR_W-1:0] err_last_q, err_prev_q;

  // Error and gating
  logic signed [ERR_W-1:0]   err;
  logic        [CMP_W-1:0]   mag;
  logic                      gate;

  assign err  = ERR_W'(tgt_q) - ERR_W'(meas_q);
  assign mag  = err[ERR_W-1] ? CMP_W'(-err) : CMP_W'(err);
  assign gate = ((error_ceiling_q != '0) && (mag > CMP_W'(error_ceiling_q))) ||
                ((dead_zone_q != '0) && (mag < CMP_W'(dead_zone_q)));

  // Error differences
  logic signed [ERR_W:0]   de1;
  logic signed [ERR_W+1:0] de2;

  assign de1 = (ERR_W+1)'(err) - (ERR_W+1)'(err_last_q);
  assign de2 = (ERR_W+2)'(err) - ((ERR_W+2)'(err_last_q) <<< 1) + (ERR_W+2)'(err_prev_q);

  // Three multipliers; the P and D operands are picked by loop form
  logic                      incr;
  logic signed [ERR_W+1:0]   kp_opnd, kd_opnd;
  logic signed [PROD_W-1:0]  prod_p, prod_i, prod_d;

  assign incr    = (loop_form_q == FORM_INCREMENTAL);
  assign kp_opnd = incr ? (ERR_W+2)'(de1) : (ERR_W+2)'(err);
  assign kd_opnd = incr ? de2 : (ERR_W+2)'(de1);
  assign prod_p  = gain_prop_q  * kp_opnd;
  assign prod_i  = gain_integ_q * (ERR_W+2)'(err);
  assign prod_d  = gain_deriv_q * kd_opnd;

  // Limits scaled to Q format
  logic signed [SUM_W-1:0] ilim, olim;

  assign ilim = SUM_W'($signed({1'b0, integ_limit_q})) <<< FRAC_BITS;
  assign olim = SUM_W'($signed({1'b0, output_limit_q})) <<< FRAC_BITS;

  // Position form: integral update then output sum
  logic signed [SUM_W-1:0] integ_new, q_pos;

  assign integ_new = clamp_sym(SUM_W'(integ_acc_q) + SUM_W'(prod_i), ilim);
  assign q_pos     = clamp_sym(SUM_W'(prod_p) + integ_new + SUM_W'(prod_d), olim);

  // Incremental form: increment added to previous output
  logic signed [SUM_W-1:0] inc, q_inc;

  assign inc   = SUM_W'(prod_p) + clamp_sym(SUM_W'(prod_i), ilim) + SUM_W'(prod_d);
  assign q_inc = clamp_sym(SUM_W'(out_prev_q) + inc, olim);

  // Truncate toward zero to the integer drive
  logic signed [SUM_W-1:0] q_sel, q_adj, q_int;
  logic signed [DRIVE_W-1:0] drive_calc;

  assign q_sel      = incr ? q_inc : q_pos;
  assign q_adj      = q_sel + (q_sel[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : SUM_W'(0));
  assign q_int      = q_adj >>> FRAC_BITS;
  assign drive_calc = gate ? DRIVE_W'(0) : q_int[DRIVE_W-1:0];

  // State update on an ungated request leaving the input register
  logic upd;
  assign upd = s1_fire && !gate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_acc_q <= '0;
      out_prev_q  <= '0;
      err_last_q  <= '0;
      err_prev_q  <= '0;
    end else if (upd) begin
      err_prev_q <= err_last_q;
      err_last_q <= err;
      if (incr) begin
        out_prev_q <= q_inc[ACC_W-1:0];
      end else begin
        integ_acc_q <= integ_new[ACC_W-1:0];
      end
    end
  end

  // Result register
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      gated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      drive_q <= drive_calc;
      gated_q <= gate;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign gated_o     = gated_q;

  // Assertions
  a_gated_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && gated_q) |-> (drive_q == '0))
    else $error("gated result with nonzero drive");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("request stalled while a register is free");

  a_hist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd |=> ($stable(err_last_q) && $stable(err_prev_q)))
    else $error("error history moved without an ungated request");

endmodule
